/* sv/ibxd_pkg.sv */
// ----------------------------------------------------------------------------
// ibxd_pkg
// Shared types and constants for the interleaved block XOR decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package ibxd_pkg;

    // default widths of the length counters and of the block size
    localparam int LENGTH_BITS_DEF = 31;
    localparam int BLOCK_BITS_DEF  = 16;

    // block_size after reset, truncated to the block width
    localparam int BS_RESET = 64;

    // depth of the queue between front and back (power of two)
    localparam int Q_DEPTH = 4;

    typedef enum logic [2:0] {
        CFG_KEY_START     = 3'd0,
        CFG_KEY_STEP      = 3'd1,
        CFG_BLOCK_SIZE    = 3'd2,
        CFG_OUTPUT_LIMIT  = 3'd3,
        CFG_STREAM_LENGTH = 3'd4
    } cfg_idx_t;

    // one queued item: raw byte plus its stream start mark
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } item_t;

    typedef enum logic [1:0] {
        BK_RUN  = 2'd0,   // ordinary bytes
        BK_MOD  = 2'd1,   // waiting for length mod block size
        BK_STEP = 2'd2    // stream start set up, first byte still to go
    } back_state_t;

endpackage

`default_nettype wire

/* sv/ibxd_front.sv */
// ----------------------------------------------------------------------------
// ibxd_front
// Input side: takes items and holds them in a short first-word-fall-through
// queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ibxd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [7:0]     data_in,
    input  wire logic           stream_start,
    output ibxd_pkg::item_t     head,
    output logic                head_valid,
    input  wire logic           pop
);

    localparam int PTR_W = $clog2(ibxd_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(ibxd_pkg::Q_DEPTH + 1);

    ibxd_pkg::item_t   q_reg [ibxd_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              push;

    assign in_stall   = (cnt_reg == CNT_W'(ibxd_pkg::Q_DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{data: data_in, start: stream_start};
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ibxd_pkg::Q_DEPTH))
        else $error("queue fill beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg != '0))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* sv/ibxd_mod.sv */
// ----------------------------------------------------------------------------
// ibxd_mod
// Restoring remainder unit: dividend mod divisor, one dividend bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ibxd_mod #(
    parameter int LENGTH_BITS = ibxd_pkg::LENGTH_BITS_DEF,
    parameter int BLOCK_BITS  = ibxd_pkg::BLOCK_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [LENGTH_BITS-1:0] dividend,
    input  wire logic [BLOCK_BITS-1:0]  divisor,
    output logic                        done,
    output logic [BLOCK_BITS-1:0]       rem
);

    localparam int CNT_W = $clog2(LENGTH_BITS + 1);

    logic [CNT_W-1:0]       cnt_reg;
    logic                   done_reg;
    logic [LENGTH_BITS-1:0] dvd_reg;
    logic [BLOCK_BITS-1:0]  rem_reg;
    logic [BLOCK_BITS:0]    trial;
    logic [BLOCK_BITS:0]    diff;
    logic                   busy;

    assign busy  = (cnt_reg != '0);
    assign trial = {rem_reg, dvd_reg[LENGTH_BITS-1]};
    assign diff  = trial - {1'b0, divisor};
    assign done  = done_reg;
    assign rem   = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(LENGTH_BITS);
            end
            else if (busy)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy)
        begin
            dvd_reg <= {dvd_reg[LENGTH_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_reg <= diff[BLOCK_BITS-1:0];
            end
            else
            begin
                rem_reg <= trial[BLOCK_BITS-1:0];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/ibxd_back.sv */
// ----------------------------------------------------------------------------
// ibxd_back
// Back end: stream set-up, block bookkeeping, XOR and output placement,
// with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ibxd_back #(
    parameter int LENGTH_BITS = ibxd_pkg::LENGTH_BITS_DEF,
    parameter int BLOCK_BITS  = ibxd_pkg::BLOCK_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // queue head
    input  wire ibxd_pkg::item_t        head,
    input  wire logic                   head_valid,
    output logic                        pop,
    // registers
    input  wire logic [7:0]             key_start,
    input  wire logic [7:0]             key_step,
    input  wire logic [BLOCK_BITS-1:0]  block_size,
    input  wire logic [LENGTH_BITS-1:0] output_limit,
    input  wire logic [LENGTH_BITS-1:0] stream_length,
    // remainder unit
    output logic                        mod_start,
    input  wire logic                   mod_done,
    input  wire logic [BLOCK_BITS-1:0]  mod_rem,
    // results
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [7:0]                  data_out,
    output logic [LENGTH_BITS-1:0]      out_offset,
    output logic                        was_decrypted
);

    localparam int L = LENGTH_BITS;
    localparam int B = BLOCK_BITS;

    ibxd_pkg::back_state_t state_reg;
    ibxd_pkg::back_state_t state_next;

    logic [7:0]   key_reg;
    logic [L-1:0] byte_pos_reg;
    logic [L-1:0] cr_reg;          // cipher bytes not yet given to a block
    logic [L-1:0] base_reg;
    logic [B-1:0] blen_reg;
    logic [B-1:0] blk_left_reg;
    logic [B-1:0] pos_reg;         // offset of the next byte inside its block
    logic         pass_reg;
    logic         out_valid_reg;
    logic [7:0]   data_out_reg;
    logic [L-1:0] out_offset_reg;
    logic         was_dec_reg;

    logic         slot_free;
    logic         step_ok;
    logic         blk_start;
    logic         emit;
    logic         decrypt;
    logic         begin_strm;

    // stream set-up
    logic [B:0]   shift;
    logic [L:0]   shift_l;
    logic [L:0]   len_l;
    logic [L:0]   len_sub;
    logic [L-1:0] cr_begin;

    // block start
    logic [L-1:0] bs_l;
    logic         block_ok;
    logic [B-1:0] n_blk;
    logic [L-1:0] cr_after;

    // per byte
    logic [B-1:0] pos_next;
    logic [L-1:0] dec_offset;

    assign slot_free = !out_valid_reg || !out_stall;

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ibxd_pkg::BK_RUN:
            begin
                if (head_valid && head.start)
                begin
                    state_next = ibxd_pkg::BK_MOD;
                end
            end
            ibxd_pkg::BK_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ibxd_pkg::BK_STEP;
                end
            end
            ibxd_pkg::BK_STEP:
            begin
                if (emit)
                begin
                    state_next = ibxd_pkg::BK_RUN;
                end
            end
            default: state_next = ibxd_pkg::BK_RUN;
        endcase
    end

    // ---- control outputs ----
    always_comb
    begin
        mod_start  = 1'b0;
        step_ok    = 1'b0;
        begin_strm = 1'b0;
        unique case (state_reg)
            ibxd_pkg::BK_RUN:
            begin
                mod_start = head_valid && head.start;
                step_ok   = head_valid && !head.start;
            end
            ibxd_pkg::BK_MOD:
            begin
                begin_strm = mod_done;
            end
            ibxd_pkg::BK_STEP:
            begin
                step_ok = head_valid;
            end
            default: step_ok = 1'b0;
        endcase
        blk_start = step_ok && !pass_reg && (blk_left_reg == '0);
        emit      = step_ok && !blk_start && slot_free;
        decrypt   = emit && !pass_reg;
        pop       = emit;
    end

    // ---- datapath ----
    always_comb
    begin
        shift    = ((mod_rem < (block_size >> 2)) ? {1'b0, mod_rem} : '0)
                   + (B+1)'(stream_length[0]);
        shift_l  = (L+1)'(shift);
        len_l    = {1'b0, stream_length};
        len_sub  = len_l - shift_l;
        if (block_size == '0 || shift_l > len_l)
        begin
            cr_begin = '0;
        end
        else
        begin
            cr_begin = len_sub[L-1:0];
        end

        bs_l     = L'(block_size);
        block_ok = (cr_reg != '0) && (block_size != '0) && (byte_pos_reg < output_limit);
        n_blk    = (cr_reg < bs_l) ? cr_reg[B-1:0] : block_size;
        cr_after = (cr_reg < bs_l) ? '0 : (cr_reg - bs_l);

        // first half walks down from n-1, second half from n-2
        pos_next   = (pos_reg < B'(2)) ? (blen_reg - B'(2)) : (pos_reg - B'(2));
        dec_offset = base_reg + L'(pos_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ibxd_pkg::BK_RUN;
            key_reg       <= '0;
            byte_pos_reg  <= '0;
            cr_reg        <= '0;
            base_reg      <= '0;
            blen_reg      <= '0;
            blk_left_reg  <= '0;
            pos_reg       <= '0;
            pass_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (begin_strm)
            begin
                key_reg      <= key_start;
                byte_pos_reg <= '0;
                base_reg     <= '0;
                blk_left_reg <= '0;
                pass_reg     <= 1'b0;
                cr_reg       <= cr_begin;
            end
            else if (blk_start)
            begin
                if (block_ok)
                begin
                    blen_reg     <= n_blk;
                    blk_left_reg <= n_blk;
                    pos_reg      <= n_blk - 1'b1;
                    base_reg     <= byte_pos_reg;
                    cr_reg       <= cr_after;
                end
                else
                begin
                    pass_reg <= 1'b1;
                end
            end
            else if (emit)
            begin
                byte_pos_reg <= byte_pos_reg + 1'b1;
                if (decrypt)
                begin
                    key_reg      <= key_reg + key_step;
                    blk_left_reg <= blk_left_reg - 1'b1;
                    pos_reg      <= pos_next;
                end
            end
            if (slot_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && emit)
        begin
            data_out_reg   <= head.data ^ (decrypt ? key_reg : 8'h00);
            out_offset_reg <= decrypt ? dec_offset : byte_pos_reg;
            was_dec_reg    <= decrypt;
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_out      = data_out_reg;
    assign out_offset    = out_offset_reg;
    assign was_decrypted = was_dec_reg;

`ifndef SYNTHESIS
    a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!out_valid_reg || !out_stall))
        else $error("item taken with result register blocked");

    a_block_not_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (blk_left_reg != '0) |-> !pass_reg)
        else $error("open block while in pass-through");

    a_pos_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        (blk_left_reg != '0) |-> (pos_reg < blen_reg))
        else $error("block position out of range");

    a_mod_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ibxd_pkg::BK_MOD && !mod_done) |=> (state_reg == ibxd_pkg::BK_MOD))
        else $error("left remainder wait early");
`endif

endmodule

`default_nettype wire

/* sv/interleaved_block_xor_decrypt.sv */
// ----------------------------------------------------------------------------
// interleaved_block_xor_decrypt
// Top level: register file, input queue, remainder unit and back end.
// ----------------------------------------------------------------------------
// Decrypts one byte stream at a time. Each item in gives exactly one item out:
// the byte, XORed with a running key or passed unchanged, together with its
// offset in the output stream. An item with stream_start set reloads the key
// from key_start and works out the cipher region from stream_length and
// block_size; that needs stream_length mod block_size, which a bit-serial
// remainder unit produces before the first byte goes out. After that, bytes
// go out at one per cycle while the queue holds items and the output is not
// stalled, with a gap at the start of every cipher block and one when the
// stream drops into pass-through. A four-deep input queue lets the source
// keep sending during those gaps, and the output register takes a new byte
// as the previous result is taken. Registers are written through the cfg
// port (always ready) and must only be written while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module interleaved_block_xor_decrypt #(
    parameter int LENGTH_BITS = ibxd_pkg::LENGTH_BITS_DEF,
    parameter int BLOCK_BITS  = ibxd_pkg::BLOCK_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [LENGTH_BITS-1:0] cfg_data,
    // input items
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             data_in,
    input  wire logic                   stream_start,
    // result items
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [7:0]                  data_out,
    output logic [LENGTH_BITS-1:0]      out_offset,
    output logic                        was_decrypted
);

    logic [7:0]             key_start_reg;
    logic [7:0]             key_step_reg;
    logic [BLOCK_BITS-1:0]  block_size_reg;
    logic [LENGTH_BITS-1:0] output_limit_reg;
    logic [LENGTH_BITS-1:0] stream_length_reg;

    ibxd_pkg::item_t        head;
    logic                   head_valid;
    logic                   pop;
    logic                   mod_start;
    logic                   mod_done;
    logic [BLOCK_BITS-1:0]  mod_rem;

    // register file; writes to unknown indexes fall through
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_start_reg     <= '0;
            key_step_reg      <= '0;
            block_size_reg    <= BLOCK_BITS'(ibxd_pkg::BS_RESET);
            output_limit_reg  <= '0;
            stream_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ibxd_pkg::CFG_KEY_START:     key_start_reg     <= cfg_data[7:0];
                ibxd_pkg::CFG_KEY_STEP:      key_step_reg      <= cfg_data[7:0];
                ibxd_pkg::CFG_BLOCK_SIZE:    block_size_reg    <= cfg_data[BLOCK_BITS-1:0];
                ibxd_pkg::CFG_OUTPUT_LIMIT:  output_limit_reg  <= cfg_data;
                ibxd_pkg::CFG_STREAM_LENGTH: stream_length_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // front: takes items into the queue
    ibxd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_in      (data_in),
        .stream_start (stream_start),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop)
    );

    // stream_length mod block_size for the stream start
    ibxd_mod #(
        .LENGTH_BITS (LENGTH_BITS),
        .BLOCK_BITS  (BLOCK_BITS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (stream_length_reg),
        .divisor  (block_size_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // back: block bookkeeping, XOR and placement
    ibxd_back #(
        .LENGTH_BITS (LENGTH_BITS),
        .BLOCK_BITS  (BLOCK_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .key_start     (key_start_reg),
        .key_step      (key_step_reg),
        .block_size    (block_size_reg),
        .output_limit  (output_limit_reg),
        .stream_length (stream_length_reg),
        .mod_start     (mod_start),
        .mod_done      (mod_done),
        .mod_rem       (mod_rem),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_out      (data_out),
        .out_offset    (out_offset),
        .was_decrypted (was_decrypted)
    );

endmodule

`default_nettype wire
